FILE: hw/rtl/arp_responder_with_cache_macros.svh
// assertion macros for the arp responder with cache
// depends on a clock named clk and an active-low reset named rst_n in the using scope
`ifndef ARP_RESPONDER_WITH_CACHE_MACROS_SVH
`define ARP_RESPONDER_WITH_CACHE_MACROS_SVH

// condition in the same cycle
`define ARP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition in the next cycle
`define ARP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// invariant on every cycle
`define ARP_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

FILE: hw/rtl/arp_pkg.sv
// shared types and constants for the arp responder with cache
// used by arp_ctrl, arp_dp and the top level; no dependencies
package arp_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [15:0] OP_REPLY    = 16'h0002;

  localparam logic [3:0] ST_BAD_HW     = 4'd0;
  localparam logic [3:0] ST_BAD_PROTO  = 4'd1;
  localparam logic [3:0] ST_NOT_OURS   = 4'd2;
  localparam logic [3:0] ST_FULL       = 4'd3;
  localparam logic [3:0] ST_REPLIED    = 4'd4;
  localparam logic [3:0] ST_ABSORBED   = 4'd5;
  localparam logic [3:0] ST_BAD_OPCODE = 4'd6;
  localparam logic [3:0] ST_HIT        = 4'd7;
  localparam logic [3:0] ST_MISS       = 4'd8;

  localparam logic REG_LOCAL_IP  = 1'b0;
  localparam logic REG_LOCAL_MAC = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        send_reply;
    logic [47:0] reply_dest_mac;
    logic [31:0] reply_dest_ip;
    logic        cache_merged;
    logic [47:0] lookup_mac;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic scan_clr;
    logic scan_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic hdr_ok;
    logic scan_done;
  } sts_t;

endpackage

FILE: hw/rtl/arp_ctrl.sv
// controller state machine for the arp responder with cache
// depends on arp_pkg; drives arp_dp through cmd_t and reads sts_t
module arp_ctrl
  import arp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  output cmd_t   cmd,
  input  sts_t   sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_stalled;

  assign out_stalled = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_clr = 1'b1;
        if (sts.is_lookup || sts.hdr_ok) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_stalled) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/arp_dp.sv
// datapath for the arp responder with cache: item register, address table,
// scan pipeline, result logic and output register; depends on arp_pkg
module arp_dp
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata,
  input  cmd_t        cmd,
  output sts_t        sts
);

  // address table, undefined until written
  logic [31:0] mem_ip  [TABLE_DEPTH];
  logic [47:0] mem_mac [TABLE_DEPTH];

  in_item_t         item_r;
  out_item_t        out_r, res;
  logic [31:0]      local_ip_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] sc_r;
  logic             pv_r;
  logic [IDX_W-1:0] pi_r;
  logic [31:0]      rd_ip_r;
  logic [47:0]      rd_mac_r;
  logic             found_r;
  logic [IDX_W-1:0] fidx_r;
  logic [47:0]      fmac_r;

  logic [31:0]      key;
  logic             hit, issue;
  logic             hw_ok, proto_ok, not_ours, full, pkt_ok;
  logic             ins, we_mac, we_ip;
  logic [IDX_W-1:0] waddr;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
    end
  end

  // only the local ip bears on results; the local mac is sourced downstream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
    end else if (cfg_valid && cfg_index == REG_LOCAL_IP) begin
      local_ip_r <= cfg_wdata[31:0];
    end
  end

  assign key      = item_r.kind ? item_r.query_ip : item_r.sender_ip;
  assign hit      = pv_r && (rd_ip_r == key);
  assign issue    = cmd.scan_step && !hit && (sc_r < count_r);
  assign hw_ok    = item_r.hw_type == HW_ETHERNET;
  assign proto_ok = item_r.proto_type == PROTO_IPV4;
  assign pkt_ok   = !item_r.kind && hw_ok && proto_ok;
  assign not_ours = item_r.target_ip != local_ip_r;
  assign full     = !found_r && (count_r >= CNT_W'(TABLE_DEPTH));

  assign sts.is_lookup = item_r.kind;
  assign sts.hdr_ok    = hw_ok && proto_ok;
  assign sts.scan_done = hit || (sc_r >= count_r);

  // scan: one table read issued per cycle, compared the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r    <= '0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      sc_r    <= '0;
      pv_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      pv_r <= issue;
      if (issue) begin
        sc_r <= sc_r + CNT_W'(1);
      end
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pi_r     <= sc_r[IDX_W-1:0];
      rd_ip_r  <= mem_ip[sc_r[IDX_W-1:0]];
      rd_mac_r <= mem_mac[sc_r[IDX_W-1:0]];
    end
    if (cmd.scan_step && hit) begin
      fidx_r <= pi_r;
      fmac_r <= rd_mac_r;
    end
  end

  // table update on finish
  assign ins    = cmd.finish && pkt_ok && !found_r && !not_ours && !full;
  assign we_mac = (cmd.finish && pkt_ok && found_r) || ins;
  assign we_ip  = ins;
  assign waddr  = found_r ? fidx_r : count_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we_mac) begin
      mem_mac[waddr] <= item_r.sender_mac;
    end
    if (we_ip) begin
      mem_ip[waddr] <= item_r.sender_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ins) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_comb begin
    res = '0;
    if (item_r.kind) begin
      if (found_r) begin
        res.status     = ST_HIT;
        res.lookup_mac = fmac_r;
      end else begin
        res.status = ST_MISS;
      end
    end else if (!hw_ok) begin
      res.status = ST_BAD_HW;
    end else if (!proto_ok) begin
      res.status = ST_BAD_PROTO;
    end else begin
      res.cache_merged = found_r;
      if (not_ours) begin
        res.status = ST_NOT_OURS;
      end else if (full) begin
        res.status = ST_FULL;
      end else if (item_r.opcode == OP_REQUEST) begin
        res.status         = ST_REPLIED;
        res.send_reply     = 1'b1;
        res.reply_dest_mac = item_r.sender_mac;
        res.reply_dest_ip  = item_r.sender_ip;
      end else if (item_r.opcode == OP_REPLY) begin
        res.status = ST_ABSORBED;
      end else begin
        res.status = ST_BAD_OPCODE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/arp_responder_with_cache.sv
// arp responder with an ipv4-to-ethernet address cache: an item is either a
// received arp header (host order) or a cache lookup, and each gives one
// result beat. The table holds TABLE_DEPTH entries filled in order and is
// searched one entry per cycle through its single read port, so the time an
// item takes from one accept to the next grows with n, the entries in use
// (up to the sixteen of a full table), and is cut short on an early match;
// a packet with a bad hardware or protocol type skips the scan. A finished result
// waits in the output register while the next item is taken in. Table
// contents are unknown after reset but only entries below the fill count
// are read, so no clearing pass is needed. Configuration writes are always
// taken; index 0 sets the local ip, index 1 the local mac, which is carried
// to the reply framer elsewhere and does not change any result here.
// depends on arp_pkg, arp_ctrl, arp_dp and arp_responder_with_cache_macros.svh
`include "arp_responder_with_cache_macros.svh"

module arp_responder_with_cache
  import arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // configuration is never held off
  assign cfg_ready = 1'b1;

  // sequencing: idle, header check, table scan, finish
  arp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table, compare pipeline and result register
  arp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a result is only produced into a free output register
  `ARP_ASSERT_IMP(a_no_overwrite, cmd.finish, !(out_valid && !out_ready), "result overwritten")
  // finishing an item always presents a beat next cycle
  `ARP_ASSERT_NXT(a_finish_valid, cmd.finish, out_valid, "finished item not presented")
  // one item at a time: busy right after an accept
  `ARP_ASSERT_NXT(a_busy_after_acc, in_valid && in_ready, !in_ready, "accepted while busy")
  // load, scan and finish never overlap
  `ARP_ASSERT_ALW(a_cmd_excl, $onehot0({cmd.load_in, cmd.scan_step, cmd.finish}), "command clash")

endmodule
